// ----- src/rgb_packet_receiver_timeout_macros.svh -----
// ---------------------------------------------------------------------------
// RGB packet receiver assertion macros
// Shared concurrent assertion forms for the receiver block.
// ---------------------------------------------------------------------------
`ifndef RGB_PACKET_RECEIVER_TIMEOUT_MACROS_SVH
`define RGB_PACKET_RECEIVER_TIMEOUT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RGBRX_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgbrx: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RGBRX_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgbrx: next-cycle check failed");

`endif

// ----- src/rgbrx_pkg.sv -----
// ---------------------------------------------------------------------------
// RGB packet receiver package
// Framing bytes, event codes and the result item type.
// ---------------------------------------------------------------------------
package rgbrx_pkg;

   localparam logic [7:0]  HEADER_BYTE   = 8'hA0;
   localparam logic [7:0]  TAIL_BYTE     = 8'hC0;
   localparam logic [7:0]  VERSION_BYTE  = 8'h76;
   localparam logic [7:0]  FULL_SCALE    = 8'hFF;
   localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
   localparam int          TICK_WIDTH    = 16;

   localparam logic [2:0] EV_HEADER   = 3'd0;
   localparam logic [2:0] EV_RED      = 3'd1;
   localparam logic [2:0] EV_GREEN    = 3'd2;
   localparam logic [2:0] EV_BLUE     = 3'd3;
   localparam logic [2:0] EV_TIMEOUT  = 3'd4;
   localparam logic [2:0] EV_COMPLETE = 3'd5;
   localparam logic [2:0] EV_VERSION  = 3'd6;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] red_compare;
      logic [7:0] green_compare;
      logic [7:0] blue_compare;
   } result_type;

endpackage

// ----- src/rgb_packet_receiver_timeout.sv -----
// ---------------------------------------------------------------------------
// RGB packet receiver with inter-byte timeout
// Parses header/red/green/blue/tail packets and loads PWM compare values.
// ---------------------------------------------------------------------------
// Feed received bytes (req_kind = 0) and timer ticks (req_kind = 1) on the
// req_ channel. A packet is header 0xA0, three colour bytes, tail 0xC0; a
// complete packet loads each compare value with 255 minus its colour. In
// idle, 'v' reports a version query and other bytes are dropped; bytes
// other than the tail are dropped while waiting for it. Ticks count only
// while a packet is open; when the count since the header or the last
// colour byte reaches csr_wr_data's last written value (reset 5000, zero
// acts like one), a timeout event is reported and the parser returns to
// idle. The parser decides and updates its state at the accepting edge;
// any event is registered into the rsp_ output at that same edge (into
// the skid register if the output is stalled). A one-entry skid register
// behind the output lets one more item be taken while a result is
// stalled, so items are accepted every cycle as long as results drain;
// req_ready drops only when the output and the skid both hold results.
// ---------------------------------------------------------------------------
`include "rgb_packet_receiver_timeout_macros.svh"

module rgb_packet_receiver_timeout
   import rgbrx_pkg::*;
#(
   parameter int TickWidth = TICK_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   // configuration
   input  logic                 csr_wr_en,
   input  logic [TickWidth-1:0] csr_wr_data,
   // input channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_kind,
   input  logic [7:0]           req_rx_byte,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [2:0]           rsp_event_res,
   output logic [7:0]           rsp_red_compare,
   output logic [7:0]           rsp_green_compare,
   output logic [7:0]           rsp_blue_compare
);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_RED   = 3'd1,
      PH_GREEN = 3'd2,
      PH_BLUE  = 3'd3,
      PH_TAIL  = 3'd4
   } phase_type;

   // parser state
   phase_type            phase_ff, phase_in;
   logic [TickWidth-1:0] tick_ff, tick_in;
   logic [TickWidth-1:0] timeout_ff;
   logic [7:0]           red_hold_ff, green_hold_ff, blue_hold_ff;
   logic [7:0]           red_hold_in, green_hold_in, blue_hold_in;
   logic [7:0]           red_cmp_ff, green_cmp_ff, blue_cmp_ff;
   logic [7:0]           red_cmp_in, green_cmp_in, blue_cmp_in;

   // output register and skid register
   result_type out_ff, skid_ff;
   logic       out_valid_ff, skid_valid_ff;

   logic             accept;
   logic             pop;
   logic             new_valid;
   logic [2:0]       new_event;
   result_type       new_result;
   logic [TickWidth:0] tick_next;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;
   assign tick_next = {1'b0, tick_ff} + {{TickWidth{1'b0}}, 1'b1};

   // Decide one item: next parser state and the event it raises, if any.
   always_comb begin
      phase_in      = phase_ff;
      tick_in       = tick_ff;
      red_hold_in   = red_hold_ff;
      green_hold_in = green_hold_ff;
      blue_hold_in  = blue_hold_ff;
      red_cmp_in    = red_cmp_ff;
      green_cmp_in  = green_cmp_ff;
      blue_cmp_in   = blue_cmp_ff;
      new_valid     = 1'b0;
      new_event     = EV_HEADER;

      if (req_kind == KIND_TICK) begin
         // timer runs only while a packet is open
         if (phase_ff inside {PH_RED, PH_GREEN, PH_BLUE, PH_TAIL}) begin
            if (tick_next >= {1'b0, timeout_ff}) begin
               tick_in   = '0;
               phase_in  = PH_IDLE;
               new_valid = 1'b1;
               new_event = EV_TIMEOUT;
            end else begin
               tick_in = tick_next[TickWidth-1:0];
            end
         end
      end else begin
         case (phase_ff)
            PH_RED: begin
               red_hold_in = req_rx_byte;
               phase_in    = PH_GREEN;
               tick_in     = '0;
               new_valid   = 1'b1;
               new_event   = EV_RED;
            end
            PH_GREEN: begin
               green_hold_in = req_rx_byte;
               phase_in      = PH_BLUE;
               tick_in       = '0;
               new_valid     = 1'b1;
               new_event     = EV_GREEN;
            end
            PH_BLUE: begin
               blue_hold_in = req_rx_byte;
               phase_in     = PH_TAIL;
               tick_in      = '0;
               new_valid    = 1'b1;
               new_event    = EV_BLUE;
            end
            PH_TAIL: begin
               // drop anything but the tail
               if (req_rx_byte == TAIL_BYTE) begin
                  red_cmp_in   = FULL_SCALE - red_hold_ff;
                  green_cmp_in = FULL_SCALE - green_hold_ff;
                  blue_cmp_in  = FULL_SCALE - blue_hold_ff;
                  phase_in     = PH_IDLE;
                  tick_in      = '0;
                  new_valid    = 1'b1;
                  new_event    = EV_COMPLETE;
               end
            end
            default: begin
               // idle, and any unused code behaves as idle
               phase_in = PH_IDLE;
               if (req_rx_byte == HEADER_BYTE) begin
                  phase_in  = PH_RED;
                  tick_in   = '0;
                  new_valid = 1'b1;
                  new_event = EV_HEADER;
               end else if (req_rx_byte == VERSION_BYTE) begin
                  new_valid = 1'b1;
                  new_event = EV_VERSION;
               end
            end
         endcase
      end

      new_result.event_res     = new_event;
      new_result.red_compare   = red_cmp_in;
      new_result.green_compare = green_cmp_in;
      new_result.blue_compare  = blue_cmp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         tick_ff       <= '0;
         timeout_ff    <= TickWidth'(TIMEOUT_RESET);
         red_hold_ff   <= '0;
         green_hold_ff <= '0;
         blue_hold_ff  <= '0;
         red_cmp_ff    <= '0;
         green_cmp_ff  <= '0;
         blue_cmp_ff   <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end

         // advance the parser on every accepted item
         if (accept) begin
            phase_ff      <= phase_in;
            tick_ff       <= tick_in;
            red_hold_ff   <= red_hold_in;
            green_hold_ff <= green_hold_in;
            blue_hold_ff  <= blue_hold_in;
            red_cmp_ff    <= red_cmp_in;
            green_cmp_ff  <= green_cmp_in;
            blue_cmp_ff   <= blue_cmp_in;
         end

         if (skid_valid_ff) begin
            // no new item possible; refill the output from the skid
            if (pop) begin
               out_ff        <= skid_ff;
               skid_valid_ff <= 1'b0;
            end
         end else if (accept && new_valid) begin
            if (!out_valid_ff || pop) begin
               out_ff       <= new_result;
               out_valid_ff <= 1'b1;
            end else begin
               // hold the new result behind the stalled one
               skid_ff       <= new_result;
               skid_valid_ff <= 1'b1;
            end
         end else if (pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_res     = out_ff.event_res;
   assign rsp_red_compare   = out_ff.red_compare;
   assign rsp_green_compare = out_ff.green_compare;
   assign rsp_blue_compare  = out_ff.blue_compare;

   // skid holds a result only behind a pending output
   `RGBRX_ASSERT_IMPL(a_skid_behind_out, clock, reset, skid_valid_ff, out_valid_ff)
   // a full skid stalls the input side
   `RGBRX_ASSERT_IMPL(a_skid_stalls, clock, reset, skid_valid_ff, !req_ready)
   // the timer is parked at zero whenever no packet is open
   `RGBRX_ASSERT_IMPL(a_idle_tick_zero, clock, reset, phase_ff == PH_IDLE, tick_ff == '0)
   // a taken output with a full skid moves the skid into the output
   `RGBRX_ASSERT_NEXT(a_skid_drain, clock, reset, skid_valid_ff && rsp_ready,
                      !skid_valid_ff && out_valid_ff)

endmodule
